@@ hdl/blsbh_pkg.sv @@
// Shared constants for the byte-lane sum bucket hash.
package blsbh_pkg;

    localparam int LANES_DEF      = 8;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int CHAR_W         = 8;
    localparam int BUCKET_W       = 32;

    // Register word indexes (byte address / 4)
    localparam logic REG_TABLE_SIZE = 1'b0;

endpackage

@@ hdl/byte_lane_sum_bucket_hash.sv @@
// Byte-lane sum bucket hash: lane accumulator and bit-serial modulo unit.
//
//  channel | signals                              | direction | width
//  --------+--------------------------------------+-----------+------
//  in      | in_valid, in_stall, key_char         | into      | 8
//  out     | out_valid, out_stall, bucket         | out of    | 32
//  cfg     | psel, penable, pwrite, paddr, pwdata | into      | 32
//
// A nonzero character is added into its lane.
// A zero character starts the modulo: one restoring subtract step per
// dividend bit (8*LANES bits, 64 at the default); the bucket is loaded
// into the output register when the last step is done and the register
// is free, and the next transaction is taken once the block is idle again.
// The input stalls during the modulo and while a finished bucket cannot
// be placed in the output register. Reset clears lanes and position, table_size to 1.
module byte_lane_sum_bucket_hash
    import blsbh_pkg::*;
#(
    parameter int LANES = LANES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CHAR_W-1:0]     key_char,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [BUCKET_W-1:0]   bucket,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DIV_BITS = CHAR_W * LANES;
    localparam int POS_W    = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CNT_W    = $clog2(DIV_BITS);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_HOLD} state_t;

    state_t                  state_reg, state_next;
    logic [CHAR_W-1:0]       lane_reg [LANES];
    logic [CHAR_W-1:0]       lane_next [LANES];
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [DIV_BITS-1:0]     dvd_reg, dvd_next;
    logic [BUCKET_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CFG_DATA_W-1:0]   table_size_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [BUCKET_W-1:0]     bucket_reg, bucket_next;

    logic                    in_acc;
    logic                    slot_free;
    logic [DIV_BITS-1:0]     lanes_flat;
    logic [BUCKET_W-1:0]     divisor;
    logic [BUCKET_W:0]       trial;
    logic [BUCKET_W:0]       diff;
    logic [BUCKET_W-1:0]     rem_step;

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_TABLE_SIZE) ? table_size_reg : '0;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign bucket    = bucket_reg;

    // A table size of zero divides by one
    assign divisor = (table_size_reg == '0) ? BUCKET_W'(1) : table_size_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            lanes_flat[CHAR_W*k +: CHAR_W] = lane_reg[k];
        end
    end

    // Shared restoring subtract step: shift in the next dividend bit
    assign trial    = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign diff     = trial - {1'b0, divisor};
    assign rem_step = diff[BUCKET_W] ? trial[BUCKET_W-1:0] : diff[BUCKET_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        lane_next      = lane_reg;
        pos_next       = pos_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        bucket_next    = bucket_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (key_char != '0)
                    begin
                        lane_next[pos_reg] = lane_reg[pos_reg] + key_char;
                        if (pos_reg == POS_W'(LANES - 1))
                        begin
                            pos_next = '0;
                        end
                        else
                        begin
                            pos_next = pos_reg + POS_W'(1);
                        end
                    end
                    else
                    begin
                        dvd_next = lanes_flat;
                        rem_next = '0;
                        cnt_next = CNT_W'(DIV_BITS - 1);
                        pos_next = '0;
                        for (int k = 0; k < LANES; k++)
                        begin
                            lane_next[k] = '0;
                        end
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[DIV_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    if (slot_free)
                    begin
                        bucket_next    = rem_step;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    bucket_next    = rem_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
            table_size_reg <= CFG_DATA_W'(1);
            cnt_reg        <= '0;
            dvd_reg        <= '0;
            rem_reg        <= '0;
            bucket_reg     <= '0;
            for (int k = 0; k < LANES; k++)
            begin
                lane_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            dvd_reg       <= dvd_next;
            rem_reg       <= rem_next;
            bucket_reg    <= bucket_next;
            lane_reg      <= lane_next;
            if (psel && penable && pwrite && pready && (paddr[2] == REG_TABLE_SIZE))
            begin
                table_size_reg <= pwdata;
            end
        end
    end

`ifndef SYNTHESIS
    // A terminator always starts the modulo
    a_term_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (key_char == '0)) |=> (state_reg == ST_DIV))
        else $error("terminator did not start the modulo");

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_HOLD) && (cnt_reg != CNT_W'(DIV_BITS - 1))
        |-> (rem_reg < divisor))
        else $error("partial remainder out of range");

    // A new bucket appears only at the end of a modulo
    a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg != ST_IDLE))
        else $error("bucket produced outside the modulo");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for the byte-lane sum bucket hash: directed and random keys against a lane-sum predictor.
module testbench
    import blsbh_pkg::*;
();

    localparam int LANE_COUNT  = LANES_DEF;
    localparam int MOD_PAUSE   = 8 * LANE_COUNT + 16;   // modulo pass plus margin
    localparam int DRAIN_LIMIT = 20000;
    localparam int MAX_WAIT    = 14;

    localparam logic [CFG_ADDR_W-1:0] ADDR_TABLE_SIZE = CFG_ADDR_W'(4 * int'(REG_TABLE_SIZE));
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED   =
        CFG_ADDR_W'(4 * (int'(REG_TABLE_SIZE) + 1));
    localparam logic [CHAR_W-1:0]     KEY_END         = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [CHAR_W-1:0]     key_char;
    logic                  out_valid;
    logic                  out_stall;
    logic [BUCKET_W-1:0]   bucket;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state
    logic [7:0]            lane_acc [LANE_COUNT];
    int unsigned           lane_pos;
    logic [CFG_DATA_W-1:0] cur_table_size;
    logic [BUCKET_W-1:0]   bucket_expect [$];

    int mismatch_count;
    int keys_sent;
    int chars_sent;
    int buckets_seen;
    int sizes_used;
    int in_quiet;
    int out_quiet;

    byte_lane_sum_bucket_hash #(
        .LANES (LANE_COUNT)
    ) u_dut (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic void note_mismatch(input string what, input logic [31:0] expected,
                                          input logic [31:0] actual);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %08h, got %08h", $realtime, what, expected,
                     actual);
    endfunction

    // Occasionally enter a quiet stretch with no waits at all.
    function automatic int pick_wait(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            quiet = $urandom_range(20, 80);
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void clear_lanes();
        foreach (lane_acc[k])
            lane_acc[k] = '0;
        lane_pos = 0;
    endfunction

    // Update lanes for an accepted character; a terminator yields the bucket.
    function automatic void hash_accept(input logic [CHAR_W-1:0] ch);
        logic [63:0] acc;
        logic [63:0] divisor;
        acc = '0;
        if (ch != KEY_END)
        begin
            lane_acc[lane_pos] = lane_acc[lane_pos] + ch;
            lane_pos = (lane_pos + 1) % LANE_COUNT;
            chars_sent++;
        end
        else
        begin
            for (int k = 0; k < LANE_COUNT; k++)
                acc[8*k +: 8] = lane_acc[k];
            // a zero table size behaves as one
            divisor = (cur_table_size == '0) ? 64'd1 : {32'd0, cur_table_size};
            bucket_expect.push_back(BUCKET_W'(acc % divisor));
            clear_lanes();
            keys_sent++;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] random_char();
        case ($urandom_range(0, 9))
            0: return 8'hFF;
            1: return 8'h01;
            2: return 8'h80;
            default: return CHAR_W'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] ch);
        int gap;
        gap = pick_wait(in_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        key_char <= ch;
        do @(posedge clk); while (in_stall !== 1'b0);
        hash_accept(ch);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_TABLE_SIZE)
            cur_table_size = data;
    endtask

    task automatic check_table_size();
        // idle bus cycle ahead of the read
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TABLE_SIZE;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== cur_table_size)
            note_mismatch("table_size readback", cur_table_size, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_table_size(input logic [CFG_DATA_W-1:0] size_val);
        cfg_write(ADDR_TABLE_SIZE, size_val);
        check_table_size();
        sizes_used++;
    endtask

    // Wait for outstanding buckets, bounded, then let a modulo pass finish.
    task automatic wait_drained();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (bucket_expect.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (MOD_PAUSE) @(posedge clk);
    endtask

    task automatic test_register_access();
        check_table_size();
        send_char(8'h41);
        send_char(KEY_END);
        wait_drained();
        // write to an unmapped address must leave table_size alone
        cfg_write(ADDR_UNMAPPED, 32'h0000_BEEF);
        check_table_size();
    endtask

    task automatic test_directed_keys();
        wait_drained();
        set_table_size(32'hFFFF_FFFF);
        send_char(KEY_END);                       // empty key
        repeat (LANE_COUNT) send_char(8'hFF);     // every lane saturated
        send_char(KEY_END);
        repeat (LANE_COUNT + 1) send_char(8'h80); // lane 0 wraps and overflows
        send_char(KEY_END);
        wait_drained();
        set_table_size('0);
        send_char(8'h55);
        send_char(8'hAA);
        send_char(KEY_END);
    endtask

    task automatic test_random_keys(input logic [CFG_DATA_W-1:0] size_val, input int budget);
        int sent;
        int len;
        int pick;
        wait_drained();
        set_table_size(size_val);
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                len = $urandom_range(1, 12);
            else if (pick < 16)
                len = 0;
            else if (pick < 18)
                len = $urandom_range(13, 40);  // long keys, many lane wraps
            else
                len = LANE_COUNT * $urandom_range(1, 3);
            repeat (len) send_char(random_char());
            send_char(KEY_END);
            sent += len + 1;
        end
    endtask

    // result checker with its own random stall
    initial
    begin
        int gap;
        logic [BUCKET_W-1:0] want;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = pick_wait(out_quiet);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            buckets_seen++;
            if (bucket_expect.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: bucket %08h with no transaction pending", $realtime, bucket);
            end
            else
            begin
                want = bucket_expect.pop_front();
                if (bucket !== want)
                    note_mismatch("bucket", want, bucket);
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        key_char       = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatch_count = 0;
        keys_sent      = 0;
        chars_sent     = 0;
        buckets_seen   = 0;
        sizes_used     = 0;
        in_quiet       = 0;
        out_quiet      = 0;
        cur_table_size = 32'd1;
        clear_lanes();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_directed_keys();
        test_random_keys(32'd1, 220);
        test_random_keys(32'hFFFF_FFFF, 220);
        test_random_keys('0, 220);
        test_random_keys(32'd2, 220);
        test_random_keys(32'd255, 220);
        test_random_keys(32'h8000_0000, 220);
        test_random_keys(CFG_DATA_W'($urandom_range(3, 300)), 220);
        test_random_keys(CFG_DATA_W'($urandom), 220);
        test_random_keys(32'd1_000_003, 220);
        wait_drained();

        if (bucket_expect.size() != 0)
        begin
            $display("%0d buckets never arrived", bucket_expect.size());
            mismatch_count += bucket_expect.size();
        end
        $display("Hashed %0d keys from %0d nonzero characters under %0d table sizes;",
                 keys_sent, chars_sent, sizes_used);
        $display("%0d buckets compared, %0d mismatches", buckets_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d buckets outstanding", bucket_expect.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
